// ===== rtl/hla_pkg.sv =====
// Shared types, codes and character constants for the header line assembler.
// No dependencies; every other file imports this package.
`default_nettype none

package hla_pkg;

  // Default size of the trailing-whitespace hold buffer.
  localparam int SPACE_DEPTH_DEFAULT = 16;

  // Depth of the operation queue between the front and back parts.
  localparam int OPQ_DEPTH = 4;

  // Input command codes. Code 3 is handled as a read error.
  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_EOF  = 2'd1;
  localparam logic [1:0] CMD_ERR  = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_EOF  = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // Characters of interest.
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  // Operations handed from the front part to the back part.
  typedef enum logic [2:0] {
    OP_PUSH1 = 3'd0,  // hold one whitespace byte
    OP_PUSH2 = 3'd1,  // hold a folded LF, then one whitespace byte
    OP_FLUSH = 3'd2,  // release held whitespace, then emit the byte
    OP_DONE  = 3'd3,  // drop held whitespace, report header complete
    OP_EOF   = 3'd4,  // drop held whitespace, report end of stream
    OP_ERR   = 3'd5   // drop held whitespace, report read error
  } op_code_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
    logic       overflow;
  } result_t;

  typedef struct packed {
    logic     pre_done;  // complete the previous header before the operation
    op_code_t code;
    logic [7:0] data;
  } op_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_HT) || (b == CH_LF) || (b == CH_CR) ||
           (b == CH_VT) || (b == CH_FF);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hla_front.sv =====
// Front part: accepts input items, tracks line state and folding, and turns
// each item into at most one queued operation. Depends on hla_pkg.
`default_nettype none

module hla_front
  import hla_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  no_continuations,
  input  wire logic  push,
  input  wire item_t item,
  input  wire logic  opq_full,
  output logic       full,
  output logic       op_valid,
  output op_t        op
);

  localparam logic [1:0] LC_NONE = 2'd0;
  localparam logic [1:0] LC_ONE  = 2'd1;
  localparam logic [1:0] LC_MANY = 2'd2;

  logic [1:0] length_class;
  logic [1:0] length_class_next;
  logic       first_was_cr;
  logic       first_was_cr_next;
  logic       newline_pending;
  logic       newline_pending_next;
  logic       accept;
  logic [1:0] tb_lc;
  logic       tb_fcr;
  logic       need_op;

  function automatic logic [1:0] lc_step(input logic [1:0] lc);
    return (lc == LC_MANY) ? LC_MANY : lc + 2'd1;
  endfunction

  assign full   = opq_full;
  assign accept = push && !opq_full;

  always_comb begin
    length_class_next    = length_class;
    first_was_cr_next    = first_was_cr;
    newline_pending_next = newline_pending;
    need_op              = 1'b0;
    op.pre_done          = 1'b0;
    op.code              = OP_FLUSH;
    op.data              = item.byte_value;
    tb_lc                = length_class;
    tb_fcr               = first_was_cr;

    if (item.command != CMD_DATA) begin
      length_class_next    = LC_NONE;
      first_was_cr_next    = 1'b0;
      newline_pending_next = 1'b0;
      need_op              = 1'b1;
      op.code              = (item.command == CMD_EOF) ? OP_EOF : OP_ERR;
    end else if (newline_pending &&
                 (item.byte_value == CH_SP || item.byte_value == CH_HT)) begin
      // Folded line: the LF and this blank both stay in the header.
      newline_pending_next = 1'b0;
      length_class_next    = lc_step(length_class);
      need_op              = 1'b1;
      op.code              = OP_PUSH2;
    end else begin
      newline_pending_next = 1'b0;
      if (newline_pending) begin
        // The pending LF ends the header; this byte starts a fresh one.
        op.pre_done = 1'b1;
        tb_lc       = LC_NONE;
        tb_fcr      = 1'b0;
      end
      if (item.byte_value == CH_LF) begin
        if (no_continuations || tb_lc == LC_NONE || (tb_lc == LC_ONE && tb_fcr)) begin
          need_op           = 1'b1;
          op.code           = OP_DONE;
          length_class_next = LC_NONE;
          first_was_cr_next = 1'b0;
        end else begin
          length_class_next    = lc_step(tb_lc);
          first_was_cr_next    = tb_fcr;
          newline_pending_next = 1'b1;
        end
      end else begin
        first_was_cr_next = tb_fcr || (tb_lc == LC_NONE && item.byte_value == CH_CR);
        length_class_next = lc_step(tb_lc);
        need_op           = 1'b1;
        op.code           = is_space(item.byte_value) ? OP_PUSH1 : OP_FLUSH;
      end
    end
  end

  assign op_valid = accept && need_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_class    <= LC_NONE;
      first_was_cr    <= 1'b0;
      newline_pending <= 1'b0;
    end else if (accept) begin
      length_class    <= length_class_next;
      first_was_cr    <= first_was_cr_next;
      newline_pending <= newline_pending_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hla_opq.sv =====
// Short operation queue that decouples the front part from the back part.
// Depends on hla_pkg for op_t and OPQ_DEPTH.
`default_nettype none

module hla_opq
  import hla_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  input  wire op_t  wr_op,
  output logic      full,
  input  wire logic rd_pop,
  output logic      empty,
  output op_t       rd_op
);

  localparam int PW = $clog2(OPQ_DEPTH);
  localparam int CW = $clog2(OPQ_DEPTH + 1);

  op_t           slots [OPQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(OPQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count == CW'(OPQ_DEPTH));
  assign empty = (count == '0);
  assign rd_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_valid) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (wr_valid && !rd_pop) begin
        count <= count + 1'b1;
      end else if (!wr_valid && rd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      slots[wr_ptr] <= wr_op;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hla_back.sv =====
// Back part: carries out queued operations against the whitespace ring
// buffer and drives the result register. Depends on hla_pkg.
`default_nettype none

module hla_back
  import hla_pkg::*;
#(
  parameter int SPACE_DEPTH = SPACE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic opq_empty,
  input  wire op_t  op_in,
  output logic      op_pop,
  output logic      empty,
  input  wire logic pop,
  output result_t   result
);

  localparam int AW = $clog2(SPACE_DEPTH);
  localparam int CW = $clog2(SPACE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_DECIDE = 2'b10
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [7:0]    space_mem [SPACE_DEPTH];
  logic [7:0]    rd_q;
  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [AW-1:0] head_inc;
  logic [CW-1:0] space_count;
  logic [CW-1:0] space_count_next;
  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic          buf_full;
  op_t           cur;
  op_t           cur_next;
  logic          wr_en;
  logic [7:0]    wr_data;
  logic          emit;
  result_t       emit_res;
  logic          res_valid;
  result_t       res_q;
  logic          slot_free;

  assign head_inc  = (head == AW'(SPACE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_sum  = (CW+1)'(head) + (CW+1)'(space_count);
  assign tail      = (tail_sum >= (CW+1)'(SPACE_DEPTH)) ?
                     AW'(tail_sum - (CW+1)'(SPACE_DEPTH)) : AW'(tail_sum);
  assign buf_full  = (space_count == CW'(SPACE_DEPTH));
  assign slot_free = !res_valid || pop;

  always_comb begin
    state_next       = state;
    head_next        = head;
    space_count_next = space_count;
    cur_next         = cur;
    wr_en            = 1'b0;
    wr_data          = cur.data;
    emit             = 1'b0;
    emit_res.kind    = KIND_BYTE;
    emit_res.out_byte = 8'h00;
    emit_res.last    = 1'b0;
    emit_res.overflow = 1'b0;
    op_pop           = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (!opq_empty) begin
          op_pop     = 1'b1;
          cur_next   = op_in;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (cur.pre_done) begin
          if (slot_free) begin
            emit              = 1'b1;
            emit_res.kind     = KIND_DONE;
            emit_res.last     = (cur.code == OP_PUSH1);
            space_count_next  = '0;
            cur_next.pre_done = 1'b0;
          end
        end else begin
          unique case (cur.code)
            OP_PUSH1: begin
              if (!buf_full) begin
                wr_en            = 1'b1;
                space_count_next = space_count + 1'b1;
                state_next       = S_IDLE;
              end else if (slot_free) begin
                emit              = 1'b1;
                emit_res.out_byte = rd_q;
                emit_res.last     = 1'b1;
                emit_res.overflow = 1'b1;
                wr_en             = 1'b1;
                head_next         = head_inc;
                state_next        = S_IDLE;
              end
            end
            OP_PUSH2: begin
              if (!buf_full) begin
                wr_en            = 1'b1;
                wr_data          = CH_LF;
                space_count_next = space_count + 1'b1;
                cur_next.code    = OP_PUSH1;
              end else if (slot_free) begin
                emit              = 1'b1;
                emit_res.out_byte = rd_q;
                emit_res.overflow = 1'b1;
                wr_en             = 1'b1;
                wr_data           = CH_LF;
                head_next         = head_inc;
                cur_next.code     = OP_PUSH1;
              end
            end
            OP_FLUSH: begin
              if (slot_free) begin
                emit = 1'b1;
                if (space_count != '0) begin
                  emit_res.out_byte = rd_q;
                  head_next         = head_inc;
                  space_count_next  = space_count - 1'b1;
                end else begin
                  emit_res.out_byte = cur.data;
                  emit_res.last     = 1'b1;
                  state_next        = S_IDLE;
                end
              end
            end
            OP_DONE, OP_EOF, OP_ERR: begin
              if (slot_free) begin
                emit             = 1'b1;
                emit_res.kind    = (cur.code == OP_DONE) ? KIND_DONE :
                                   (cur.code == OP_EOF)  ? KIND_EOF : KIND_ERR;
                emit_res.last    = 1'b1;
                space_count_next = '0;
                state_next       = S_IDLE;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The oldest held byte is registered in rd_q ahead of its use.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      space_mem[tail] <= wr_data;
    end
    rd_q <= space_mem[head_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      space_count <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      head        <= head_next;
      space_count <= space_count_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (emit) begin
      res_q <= emit_res;
    end
  end

  assign empty  = !res_valid;
  assign result = res_q;

endmodule

`default_nettype wire

// ===== rtl/header_line_assembler.sv =====
// Top level of the header line assembler: front part, operation queue and
// back part. Depends on hla_pkg, hla_front, hla_opq and hla_back.
//
// Usage: items enter through a queue-style port. An item transaction takes
// place at a rising edge with push high and full low; item carries a command
// (data byte, end of stream, read error) and the byte. Results leave through
// a second queue-style port: while empty is low, result holds the oldest
// waiting result, and a transaction takes place at an edge with pop high.
// The single configuration bit, no_continuations, is written through
// cfg_valid/cfg_ready/cfg_data; cfg_ready is always high. Write it only while
// the block is idle.
// With an idle back part, an item's operation is written into the queue at
// the item transaction; the back part fetches it in S_IDLE and executes it
// in S_DECIDE, which registers its first result. The back part works on one
// queued operation at a time and takes an extra execute step per extra
// result, such as each held whitespace byte released by a flush or a header
// completed ahead of the item's own work. A folded line takes an extra step
// to hold its LF. Items that only set a pending newline queue no operation.
// Reset (synchronous, rst high) empties the queue and the whitespace buffer,
// clears the line state and sets no_continuations to 0.
// When the receiver stalls, the back part holds its operation, the four-entry
// operation queue fills and full rises until results are taken again.
`default_nettype none

module header_line_assembler
  import hla_pkg::*;
#(
  parameter int SPACE_DEPTH = SPACE_DEPTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       full,
  input  wire item_t item,
  output logic       empty,
  input  wire logic  pop,
  output result_t    result,
  input  wire logic  cfg_valid,
  output logic       cfg_ready,
  input  wire logic  cfg_data
);

  logic no_continuations;
  logic op_valid;
  op_t  op_front;
  op_t  op_back;
  logic opq_full;
  logic opq_empty;
  logic op_pop;

  // Configuration is always accepted; it only matters between items.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      no_continuations <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      no_continuations <= cfg_data;
    end
  end

  // The front part classifies each item against the line state and queues
  // at most one operation for it.
  hla_front u_front (
    .clk              (clk),
    .rst              (rst),
    .no_continuations (no_continuations),
    .push             (push),
    .item             (item),
    .opq_full         (opq_full),
    .full             (full),
    .op_valid         (op_valid),
    .op               (op_front)
  );

  hla_opq u_opq (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (op_valid),
    .wr_op    (op_front),
    .full     (opq_full),
    .rd_pop   (op_pop),
    .empty    (opq_empty),
    .rd_op    (op_back)
  );

  // The back part owns the whitespace buffer and produces every result.
  hla_back #(
    .SPACE_DEPTH (SPACE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .opq_empty (opq_empty),
    .op_in     (op_back),
    .op_pop    (op_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

`ifndef ASSERT_OFF
  // The back part never takes an operation from an empty queue.
  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    op_pop |-> !opq_empty)
    else $error("operation taken from an empty queue");

  // The front part never queues an operation while the queue is full.
  a_no_overfill : assert property (@(posedge clk) disable iff (rst)
    opq_full |-> !op_valid)
    else $error("operation queued while the queue is full");

  // An accepted end-of-stream or error item always leaves an operation queued.
  a_abort_queued : assert property (@(posedge clk) disable iff (rst)
    (push && !full && item.command != CMD_DATA) |=> !opq_empty)
    else $error("end or error transaction produced no operation");
`endif

endmodule

`default_nettype wire
